// ===== hw/rtl/sfd_pkg.sv =====
// stereo flanger shared package: config register codes, lane config bundle
// and the quarter-wave sine entry function; no dependencies
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int DELAY_DEPTH_DEF      = 1024;
    localparam int SAMPLE_BITS_DEF      = 24;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LFO_STEP    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_DELAY  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SWEEP_DEPTH = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGEN_GAIN  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TONE_COEF   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIX_AMOUNT  = 3'd5;

    localparam logic [31:0] RST_LFO_STEP    = 32'd8947849;
    localparam logic [17:0] RST_BASE_DELAY  = 18'd7373;
    localparam logic [17:0] RST_SWEEP_DEPTH = 18'd30720;
    localparam logic [15:0] RST_REGEN_GAIN  = 16'd29491;
    localparam logic [16:0] RST_TONE_COEF   = 17'd26214;
    localparam logic [16:0] RST_MIX_AMOUNT  = 17'd26214;

    localparam logic [31:0] RIGHT_PHASE_LEAD = 32'h4000_0000;

    typedef struct packed {
        logic [17:0] base_delay;
        logic [17:0] sweep_depth;
        logic [15:0] regen_gain;
        logic [16:0] tone_coef;
        logic [16:0] mix_amount;
    } t_lane_cfg;

    // sine polynomial in q16, halved and clamped to 0..32768
    function automatic logic [15:0] sine_entry(input longint t);
        longint t2;
        longint p;
        longint s;
        t2 = (t * t) / 65536;
        p  = -307;
        p  = 5223 + (p * t2) / 65536;
        p  = -42334 + (p * t2) / 65536;
        p  = 102944 + (p * t2) / 65536;
        s  = ((p * t) / 65536) / 2;
        if (s < 0) s = 0;
        if (s > 32768) s = 32768;
        return 16'(s);
    endfunction

endpackage

// ===== hw/rtl/sfd_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sfd_lane.sv =====
// one flanger channel: lfo lookup, delay ring with interpolated read,
// tone low-pass, feedback write and dry/wet mix; uses sfd_pkg and sfd_ram
`timescale 1ns / 1ps

module sfd_lane #(
    parameter int DELAY_DEPTH      = sfd_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS      = sfd_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = sfd_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [31:0]                         i_phase,
    input  logic signed [SAMPLE_BITS-1:0]       i_x,
    input  logic [$clog2(DELAY_DEPTH)-1:0]      i_wp,
    input  logic [$clog2(DELAY_DEPTH):0]        i_fill,
    input  sfd_pkg::t_lane_cfg                  i_cfg,
    output logic                                o_done,
    output logic signed [SAMPLE_BITS-1:0]       o_y
);

    localparam int S    = SAMPLE_BITS;
    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int IW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int RW   = AW + 10;
    localparam logic [31:0] MAXD = 32'((DELAY_DEPTH - 1) * 256);
    localparam logic [RW-1:0] SPAN = RW'(DELAY_DEPTH * 256);

    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_DLY  = 4'd2;
    localparam logic [3:0] ST_ADR  = 4'd3;
    localparam logic [3:0] ST_RDA  = 4'd4;
    localparam logic [3:0] ST_RDB  = 4'd5;
    localparam logic [3:0] ST_GETB = 4'd6;
    localparam logic [3:0] ST_FRAC = 4'd7;
    localparam logic [3:0] ST_WET  = 4'd8;
    localparam logic [3:0] ST_TONE = 4'd9;
    localparam logic [3:0] ST_LP   = 4'd10;
    localparam logic [3:0] ST_FB   = 4'd11;
    localparam logic [3:0] ST_WR   = 4'd12;
    localparam logic [3:0] ST_MIX  = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    function automatic logic signed [S-1:0] sat(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (S - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return S'(hi);
        if (v < lo) return S'(lo);
        return S'(v);
    endfunction

    logic [15:0] w_sine [0:SINE_TABLE_DEPTH];

    genvar k;
    generate
        for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
            localparam longint T = (longint'(k) * 65536) / SINE_TABLE_DEPTH;
            assign w_sine[k] = sfd_pkg::sine_entry(T);
        end
    endgenerate

    logic [3:0]            r_step;
    logic                  r_run;
    logic                  r_done;
    logic [16:0]           r_lfo;
    logic [34:0]           r_prod;
    logic [AW+7:0]         r_dly;
    logic [AW-1:0]         r_i0;
    logic [AW-1:0]         r_i1;
    logic [7:0]            r_fr;
    logic signed [S-1:0]   r_a;
    logic signed [S-1:0]   r_b;
    logic signed [S+9:0]   r_ip;
    logic signed [S+1:0]   r_wet;
    logic signed [S+19:0]  r_tp;
    logic signed [S-1:0]   r_lp;
    logic signed [S+16:0]  r_fb;
    logic signed [S+18:0]  r_m1;
    logic signed [S+18:0]  r_m2;
    logic signed [S-1:0]   r_y;

    logic [42:0]           w_pmul;
    logic [IW-1:0]         w_idx;
    logic [IW-1:0]         w_sidx;
    logic [15:0]           w_ent;
    logic [19:0]           w_draw;
    logic [RW-1:0]         w_rp0;
    logic [RW-1:0]         w_rp;
    logic [AW-1:0]         w_i0;
    logic [AW-1:0]         w_raddr;
    logic [S-1:0]          w_rdata;
    logic                  w_we;
    logic signed [S-1:0]   w_wdata;
    logic signed [S:0]     w_diff;
    logic signed [S+1:0]   w_dlp;
    logic [17:0]           w_dry;
    logic signed [S+19:0]  w_mix;

    // lfo lookup
    assign w_pmul = 43'(i_phase[29:0]) * 43'(SINE_TABLE_DEPTH);
    assign w_idx  = IW'(w_pmul >> 30);
    assign w_sidx = i_phase[30] ? (IW'(SINE_TABLE_DEPTH) - w_idx) : w_idx;
    assign w_ent  = w_sine[w_sidx];

    // read position
    assign w_draw = 20'(i_cfg.base_delay) + 20'(r_prod >> 16);
    assign w_rp0  = RW'({i_wp, 8'd0}) + SPAN - RW'(r_dly);
    assign w_rp   = (w_rp0 >= SPAN) ? (w_rp0 - SPAN) : w_rp0;
    assign w_i0   = AW'(w_rp >> 8);

    assign w_raddr = (r_step == ST_RDA) ? r_i0 : r_i1;
    assign w_diff  = (S+1)'(r_b) - (S+1)'(r_a);
    assign w_dlp   = (S+2)'(r_wet) - (S+2)'(r_lp);
    assign w_dry   = 18'(18'd131072 - {1'b0, i_cfg.mix_amount});
    assign w_mix   = (S+20)'(r_m1) + (S+20)'(r_m2);

    assign w_we    = r_run && (r_step == ST_WR);
    assign w_wdata = sat(64'(i_x) + 64'(r_fb >>> 16));

    sfd_ram #(
        .WIDTH (S),
        .DEPTH (DELAY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_wp),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= ST_MUL;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_step == ST_OUT);
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= ST_MUL;
            end else if (r_run) begin
                if (r_step == ST_OUT) begin
                    r_run <= 1'b0;
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end
        end
    end

    // low-pass state clears at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
        end else if (i_start) begin
            r_lfo <= i_phase[31] ? (17'd32768 - 17'(w_ent)) : (17'd32768 + 17'(w_ent));
        end else if (r_run) begin
            unique case (r_step)
                ST_MUL: begin
                    r_prod <= 35'(i_cfg.sweep_depth) * 35'(r_lfo);
                end
                ST_DLY: begin
                    r_dly <= ({12'd0, w_draw} > MAXD) ? (AW+8)'(MAXD) : (AW+8)'(w_draw);
                end
                ST_ADR: begin
                    r_i0 <= w_i0;
                    r_i1 <= (w_i0 == AW'(DELAY_DEPTH - 1)) ? '0 : (w_i0 + AW'(1));
                    r_fr <= w_rp[7:0];
                end
                ST_RDA: begin
                end
                ST_RDB: begin
                    r_a <= ({1'b0, r_i0} < i_fill) ? w_rdata : '0;
                end
                ST_GETB: begin
                    r_b <= ({1'b0, r_i1} < i_fill) ? w_rdata : '0;
                end
                ST_FRAC: begin
                    r_ip <= (S+10)'($signed({1'b0, r_fr})) * (S+10)'(w_diff);
                end
                ST_WET: begin
                    r_wet <= (S+2)'(r_a) + (S+2)'(r_ip >>> 8);
                end
                ST_TONE: begin
                    r_tp <= (S+20)'($signed({1'b0, i_cfg.tone_coef})) * (S+20)'(w_dlp);
                end
                ST_LP: begin
                    r_lp <= sat(64'(r_lp) + 64'(r_tp >>> 16));
                end
                ST_FB: begin
                    r_fb <= (S+17)'(r_lp) * (S+17)'($signed({1'b0, i_cfg.regen_gain}));
                end
                ST_WR: begin
                    r_m1 <= (S+19)'(i_x) * (S+19)'($signed({1'b0, w_dry}));
                end
                ST_MIX: begin
                    r_m2 <= (S+19)'(r_lp)
                            * (S+19)'($signed({1'b0, i_cfg.mix_amount, 1'b0}));
                end
                ST_OUT: begin
                    r_y <= sat(64'(w_mix >>> 17));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

// ===== hw/rtl/stereo_flanger_delay.sv =====
// stereo flanger top level: config registers, lfo phase, ring pointers,
// two channel lanes and the output stage; uses sfd_pkg and sfd_lane
`timescale 1ns / 1ps

// One stereo frame in, one stereo frame out. Between a frame's input transfer
// and its output being offered, the frame is registered and each channel lane
// runs a fixed sequence of lfo lookup, delay multiply, two reads on the
// single read port of its ring, interpolation, low-pass, feedback write and
// mix, one multiplier per step. Both lanes run side by side and the output
// register holds the finished frame, so the next frame is taken as soon as
// the current one has moved into it. The rings need no clearing pass: a
// fill count marks entries never written, which read as zero, so the block
// takes frames right after reset. Config writes are always ready and must
// only be issued while no frame is in flight.
module stereo_flanger_delay #(
    parameter int DELAY_DEPTH      = sfd_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS      = sfd_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = sfd_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]         i_right_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_left_out,
    output logic signed [SAMPLE_BITS-1:0]         o_right_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);

    logic [31:0]              r_lfo_step;
    sfd_pkg::t_lane_cfg       r_cfg;
    logic [31:0]              r_phase;
    logic signed [SAMPLE_BITS-1:0] r_xl;
    logic signed [SAMPLE_BITS-1:0] r_xr;
    logic                     r_busy;
    logic                     r_start;
    logic                     r_pend;
    logic [AW-1:0]            r_wp;
    logic [AW:0]              r_fill;
    logic                     r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_outl;
    logic signed [SAMPLE_BITS-1:0] r_outr;

    logic                     w_in_xfer;
    logic                     w_load;
    logic                     w_done_l;
    logic                     w_done_r;
    logic signed [SAMPLE_BITS-1:0] w_yl;
    logic signed [SAMPLE_BITS-1:0] w_yr;

    assign w_in_xfer = i_in_valid && !r_busy;
    assign w_load    = r_pend && (!r_ovalid || !i_out_stall);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfo_step        <= sfd_pkg::RST_LFO_STEP;
            r_cfg.base_delay  <= sfd_pkg::RST_BASE_DELAY;
            r_cfg.sweep_depth <= sfd_pkg::RST_SWEEP_DEPTH;
            r_cfg.regen_gain  <= sfd_pkg::RST_REGEN_GAIN;
            r_cfg.tone_coef   <= sfd_pkg::RST_TONE_COEF;
            r_cfg.mix_amount  <= sfd_pkg::RST_MIX_AMOUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfd_pkg::CFG_LFO_STEP:    r_lfo_step        <= i_cfg_data;
                sfd_pkg::CFG_BASE_DELAY:  r_cfg.base_delay  <= i_cfg_data[17:0];
                sfd_pkg::CFG_SWEEP_DEPTH: r_cfg.sweep_depth <= i_cfg_data[17:0];
                sfd_pkg::CFG_REGEN_GAIN:  r_cfg.regen_gain  <= i_cfg_data[15:0];
                sfd_pkg::CFG_TONE_COEF:   r_cfg.tone_coef   <= i_cfg_data[16:0];
                sfd_pkg::CFG_MIX_AMOUNT:  r_cfg.mix_amount  <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    // frame control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_busy   <= 1'b0;
            r_start  <= 1'b0;
            r_pend   <= 1'b0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= w_in_xfer;
            if (w_in_xfer) begin
                r_busy  <= 1'b1;
                r_phase <= r_phase + r_lfo_step;
            end
            if (w_done_l) begin
                r_pend <= 1'b1;
            end
            if (w_load) begin
                r_pend   <= 1'b0;
                r_busy   <= 1'b0;
                r_ovalid <= 1'b1;
                r_wp     <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : (r_wp + AW'(1));
                if (r_fill != (AW+1)'(DELAY_DEPTH)) begin
                    r_fill <= r_fill + (AW+1)'(1);
                end
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_xl <= i_left_sample;
            r_xr <= i_right_sample;
        end
        if (w_load) begin
            r_outl <= w_yl;
            r_outr <= w_yr;
        end
    end

    sfd_lane #(
        .DELAY_DEPTH      (DELAY_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lane_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_phase (r_phase),
        .i_x     (r_xl),
        .i_wp    (r_wp),
        .i_fill  (r_fill),
        .i_cfg   (r_cfg),
        .o_done  (w_done_l),
        .o_y     (w_yl)
    );

    sfd_lane #(
        .DELAY_DEPTH      (DELAY_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_phase (r_phase + sfd_pkg::RIGHT_PHASE_LEAD),
        .i_x     (r_xr),
        .i_wp    (r_wp),
        .i_fill  (r_fill),
        .i_cfg   (r_cfg),
        .o_done  (w_done_r),
        .o_y     (w_yr)
    );

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_ovalid;
    assign o_left_out  = r_outl;
    assign o_right_out = r_outr;
    assign o_cfg_ready = 1'b1 | w_done_r;

endmodule

// ===== hw/rtl/sfd_chk.sv =====
// port-level checker for the stereo flanger, attached by bind
// uses only the top-level ports
`timescale 1ns / 1ps

module sfd_chk #(
    parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [SAMPLE_BITS-1:0] o_left_out,
    input logic signed [SAMPLE_BITS-1:0] o_right_out
);

    // a transfer in holds off the next frame
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a new result only appears while a frame was in flight
    a_out_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without frame in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_left_out)
                                          && $stable(o_right_out)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind stereo_flanger_delay sfd_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sfd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_left_out  (o_left_out),
    .o_right_out (o_right_out)
);

// ===== bench/stereo_flanger_delay_tb.sv =====
// testbench for stereo_flanger_delay: queue-fed driver and monitor with a
// frame-level flanger predictor; depends on sfd_pkg and the rtl top level
`timescale 1ns / 1ps

module stereo_flanger_delay_tb;
    import sfd_pkg::*;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } frame_t;

    typedef struct {
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } reg_wr_t;

    localparam int  RING_WORDS = 1024;
    localparam int  WD_LIMIT   = 5000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic signed [23:0] i_left_sample;
    logic signed [23:0] i_right_sample;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [23:0] o_left_out;
    logic signed [23:0] o_right_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    stereo_flanger_delay dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_left_sample(i_left_sample), .i_right_sample(i_right_sample),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_left_out(o_left_out), .o_right_out(o_right_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    frame_t  frame_q[$];
    frame_t  flanged_q[$];
    reg_wr_t reg_q[$];
    int      fails;
    int      wd_count;
    bit      quiet;

    // predictor state
    logic [31:0] m_lfo_step;
    logic [17:0] m_base, m_sweep;
    logic [15:0] m_regen;
    logic [16:0] m_tone, m_mix;
    longint      ring[2][RING_WORDS];
    longint      lp_state[2];
    int          wr_ptr;
    logic [31:0] phase;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint quarter_sine(int k);
        longint t, t2, acc, s;
        t   = longint'(k) * 256;
        t2  = (t * t) / 65536;
        acc = -307;
        acc = 5223 + (acc * t2) / 65536;
        acc = -42334 + (acc * t2) / 65536;
        acc = 102944 + (acc * t2) / 65536;
        s   = ((acc * t) / 65536) / 2;
        if (s < 0) s = 0;
        if (s > 32768) s = 32768;
        return s;
    endfunction

    function automatic longint lfo_of(logic [31:0] ph);
        int k;
        longint s;
        k = int'(ph[29:22]);
        if (ph[30]) k = 256 - k;
        s = quarter_sine(k);
        if (ph[31]) s = -s;
        return 32768 + s;
    endfunction

    function longint flange_lane(int ch, longint x, longint lfo);
        longint dly, rp, a, b, fr, wet;
        int i0, i1;
        dly = longint'(m_base) + ((longint'(m_sweep) * lfo) >>> 16);
        if (dly > (RING_WORDS - 1) * 256) dly = (RING_WORDS - 1) * 256;
        rp = longint'(wr_ptr) * 256 + RING_WORDS * 256 - dly;
        if (rp >= RING_WORDS * 256) rp -= RING_WORDS * 256;
        i0 = int'(rp >>> 8) % RING_WORDS;
        fr = rp & 255;
        i1 = (i0 + 1) % RING_WORDS;
        a = ring[ch][i0];
        b = ring[ch][i1];
        wet = a + ((fr * (b - a)) >>> 8);
        lp_state[ch] = sat24(lp_state[ch] + ((longint'(m_tone) * (wet - lp_state[ch])) >>> 16));
        ring[ch][wr_ptr] = sat24(x + ((lp_state[ch] * longint'(m_regen)) >>> 16));
        return sat24((x * (131072 - longint'(m_mix)) + lp_state[ch] * longint'(m_mix) * 2)
                     >>> 17);
    endfunction

    task automatic flange_frame(input logic signed [23:0] xl, input logic signed [23:0] xr);
        frame_t f;
        phase   = phase + m_lfo_step;
        f.left  = 24'(flange_lane(0, longint'(xl), lfo_of(phase)));
        f.right = 24'(flange_lane(1, longint'(xr), lfo_of(phase + RIGHT_PHASE_LEAD)));
        wr_ptr  = (wr_ptr + 1) % RING_WORDS;
        flanged_q.push_back(f);
    endtask

    task automatic apply_reg(input reg_wr_t w);
        case (w.idx)
            CFG_LFO_STEP:    m_lfo_step = w.data;
            CFG_BASE_DELAY:  m_base     = w.data[17:0];
            CFG_SWEEP_DEPTH: m_sweep    = w.data[17:0];
            CFG_REGEN_GAIN:  m_regen    = w.data[15:0];
            CFG_TONE_COEF:   m_tone     = w.data[16:0];
            CFG_MIX_AMOUNT:  m_mix      = w.data[16:0];
            default: ;
        endcase
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 12);
    endfunction

    // driver for frames and register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid     <= 1'b0;
            i_left_sample  <= '0;
            i_right_sample <= '0;
            i_cfg_valid    <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                flange_frame(i_left_sample, i_right_sample);
            if (!i_in_valid || !o_in_stall) begin
                if (frame_q.size() > 0 && !idle_now()) begin
                    i_in_valid     <= 1'b1;
                    i_left_sample  <= frame_q[0].left;
                    i_right_sample <= frame_q[0].right;
                    void'(frame_q.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                apply_reg('{i_cfg_index, i_cfg_data});
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_q.size() > 0) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= reg_q[0].idx;
                    i_cfg_data  <= reg_q[0].data;
                    void'(reg_q.pop_front());
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (flanged_q.size() == 0) begin
                    report("unexpected transfer", longint'(o_left_out), 0);
                end else begin
                    if (o_left_out !== flanged_q[0].left)
                        report("left_out", longint'(o_left_out), longint'(flanged_q[0].left));
                    if (o_right_out !== flanged_q[0].right)
                        report("right_out", longint'(o_right_out),
                               longint'(flanged_q[0].right));
                    void'(flanged_q.pop_front());
                end
            end
            i_out_stall <= idle_now();
        end
    end

    // watchdog on transfer-free cycles
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            wd_count <= 0;
        end else begin
            wd_count <= wd_count + 1;
            if (wd_count >= WD_LIMIT) begin
                $display("watchdog timeout at %0t", $realtime);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3, 4, 5: return 24'($urandom);
            default: return 24'($urandom_range(4095)) - 24'd2048;
        endcase
    endfunction

    task automatic push_frame(input logic [23:0] l, input logic [23:0] r);
        frame_q.push_back('{l, r});
    endtask

    task automatic push_random(input int n);
        repeat (n) push_frame(pick_sample(), pick_sample());
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        reg_q.push_back('{idx, data});
    endtask

    task automatic write_all(input logic [31:0] step, input logic [31:0] base,
                             input logic [31:0] sweep, input logic [31:0] regen,
                             input logic [31:0] tone, input logic [31:0] mix);
        write_reg(CFG_LFO_STEP, step);
        write_reg(CFG_BASE_DELAY, base);
        write_reg(CFG_SWEEP_DEPTH, sweep);
        write_reg(CFG_REGEN_GAIN, regen);
        write_reg(CFG_TONE_COEF, tone);
        write_reg(CFG_MIX_AMOUNT, mix);
    endtask

    task automatic drain_block();
        while (frame_q.size() > 0 || i_in_valid || flanged_q.size() > 0
               || reg_q.size() > 0 || i_cfg_valid)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        fails       = 0;
        quiet       = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_left_sample  = '0;
        i_right_sample = '0;
        m_lfo_step = RST_LFO_STEP;
        m_base     = RST_BASE_DELAY;
        m_sweep    = RST_SWEEP_DEPTH;
        m_regen    = RST_REGEN_GAIN;
        m_tone     = RST_TONE_COEF;
        m_mix      = RST_MIX_AMOUNT;
        for (int i = 0; i < RING_WORDS; i++) begin
            ring[0][i] = 0;
            ring[1][i] = 0;
        end
        lp_state[0] = 0;
        lp_state[1] = 0;
        wr_ptr = 0;
        phase  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed extremes under reset settings
        push_frame(24'h7FFFFF, 24'h800000);
        push_frame(24'h800000, 24'h7FFFFF);
        push_frame(24'h7FFFFF, 24'h7FFFFF);
        push_frame(24'h800000, 24'h800000);
        push_frame(24'h000000, 24'h000000);
        push_frame(24'hFFFFFF, 24'h000001);
        push_frame(24'h555555, 24'hAAAAAA);
        push_frame(24'hAAAAAA, 24'h555555);
        repeat (6) push_frame(24'h7FFFFF, 24'h800000);
        drain_block();

        // zero delay reads the word about to be overwritten
        write_all(32'd0, 32'd0, 32'd0, 32'd58982, 32'd65536, 32'd65536);
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        drain_block();
        push_random(40);
        drain_block();

        // long delay clamped, lfo phase stepping backward by one
        write_all(32'hFFFF_FFFF, 32'h3FFFF, 32'h3FFFF, 32'd58982, 32'd0, 32'd0);
        drain_block();
        push_random(120);
        drain_block();

        // registers past their nominal range, no idling
        quiet = 1;
        write_all($urandom, 32'd300, 32'd60000, 32'd65535, 32'd131071, 32'd131071);
        drain_block();
        push_random(130);
        drain_block();
        quiet = 0;

        for (int ph = 0; ph < 5; ph++) begin
            write_all($urandom_range(2) == 0 ? $urandom : $urandom_range(50000000),
                      $urandom_range(40000), $urandom_range(262143),
                      $urandom_range(58982), $urandom_range(65536),
                      $urandom_range(65536));
            drain_block();
            push_random(90);
            drain_block();
        end

        if (flanged_q.size() > 0)
            report("leftover expected frames", flanged_q.size(), 0);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
